### hw/rtl/allfl_pkg.sv
// Shared types and codes for the array linked list with free list.
// Holds operation, status and register codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package allfl_pkg;

  localparam int OP_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_LIST_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREE_START = 2'd1;

  typedef struct packed {
    logic capture;
    logic walk_init;
    logic step;
    logic load_wr;
    logic fail_free;
    logic fail_pos;
    logic ins_head;
    logic ins_tmp;
    logic ins_wr;
    logic ins_link;
    logic rem_unlink;
    logic rem_free;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_one;
    logic            k_bad;
    logic            free_ok;
    logic            rem_zero;
    logic            rem_one;
    logic            cur_ok;
    logic            rd_ok;
    logic            out_busy;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/allfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module allfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/allfl_dpath.sv
// Datapath: list heads, walk registers, node tables and output register.
// Depends on allfl_pkg and allfl_ram.
`default_nettype none

module allfl_dpath #(
  parameter int NODE_COUNT   = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire allfl_pkg::cmd_t                     cmd,
  output allfl_pkg::stat_t                         stat,
  input  wire logic [allfl_pkg::OP_W-1:0]          in_op,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0]     in_num,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0]     in_pos,
  input  wire logic [PAYLOAD_BITS-1:0]             in_pay,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0]     in_lnk,
  input  wire logic                                cfg_we,
  input  wire logic [allfl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0]     cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic      [allfl_pkg::STATUS_W-1:0]      out_status,
  output logic      [$clog2(NODE_COUNT+1)-1:0]     out_node,
  output logic      [PAYLOAD_BITS-1:0]             out_pay
);

  localparam int LINK_W = $clog2(NODE_COUNT+1);
  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam logic [LINK_W:0] N_EXT    = (LINK_W+1)'(NODE_COUNT);
  localparam logic [LINK_W:0] N_P1_EXT = (LINK_W+1)'(NODE_COUNT + 1);

  function automatic logic node_ok(input logic [LINK_W-1:0] n);
    return (n != '0) && ({1'b0, n} <= N_EXT);
  endfunction

  function automatic logic [ADDR_W-1:0] idx(input logic [LINK_W-1:0] n);
    logic [LINK_W-1:0] m;
    m = n - LINK_W'(1);
    return m[ADDR_W-1:0];
  endfunction

  logic [allfl_pkg::OP_W-1:0]     op_r;
  logic [LINK_W-1:0]              num_r;
  logic [LINK_W-1:0]              pos_r;
  logic [PAYLOAD_BITS-1:0]        pay_r;
  logic [LINK_W-1:0]              lnk_r;
  logic [LINK_W-1:0]              list_head_r;
  logic [LINK_W-1:0]              free_head_r;
  logic [LINK_W-1:0]              cur_r;
  logic [LINK_W-1:0]              prev_r;
  logic [LINK_W-1:0]              rem_r;
  logic [LINK_W-1:0]              tmp_r;
  logic [allfl_pkg::STATUS_W-1:0] res_status_r;
  logic [LINK_W-1:0]              res_node_r;
  logic [PAYLOAD_BITS-1:0]        res_pay_r;
  logic                           out_valid_r;
  logic [allfl_pkg::STATUS_W-1:0] out_status_r;
  logic [LINK_W-1:0]              out_node_r;
  logic [PAYLOAD_BITS-1:0]        out_pay_r;

  logic                    lk_we;
  logic [ADDR_W-1:0]       lk_waddr;
  logic [LINK_W-1:0]       lk_wdata;
  logic [ADDR_W-1:0]       lk_raddr;
  logic [LINK_W-1:0]       lk_rdata;
  logic                    py_we;
  logic [ADDR_W-1:0]       py_waddr;
  logic [PAYLOAD_BITS-1:0] py_wdata;
  logic [PAYLOAD_BITS-1:0] py_rdata;
  logic                    pos_one;
  logic [LINK_W-1:0]       rem_init;

  assign pos_one  = (pos_r == LINK_W'(1));
  assign rem_init = (op_r == allfl_pkg::OP_INSERT) ? (pos_r - LINK_W'(2))
                                                   : (pos_r - LINK_W'(1));

  always_comb begin
    stat.op       = op_r;
    stat.pos_one  = pos_one;
    if (op_r == allfl_pkg::OP_REMOVE) begin
      stat.k_bad = (pos_r == '0) || ({1'b0, pos_r} > N_EXT);
    end else begin
      stat.k_bad = (pos_r == '0) || ({1'b0, pos_r} > N_P1_EXT);
    end
    stat.free_ok  = node_ok(free_head_r);
    stat.rem_zero = (rem_r == '0);
    stat.rem_one  = (rem_r == LINK_W'(1));
    stat.cur_ok   = node_ok(cur_r);
    stat.rd_ok    = node_ok(lk_rdata);
    stat.out_busy = out_valid_r && !out_ready;
  end

  // link table ports
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = idx(cur_r);
    lk_wdata = free_head_r;
    if (cmd.load_wr) begin
      lk_we    = node_ok(num_r);
      lk_waddr = idx(num_r);
      lk_wdata = lnk_r;
    end else if (cmd.ins_wr) begin
      lk_we    = 1'b1;
      lk_waddr = idx(free_head_r);
      lk_wdata = tmp_r;
    end else if (cmd.ins_link) begin
      lk_we    = !pos_one;
      lk_waddr = idx(cur_r);
      lk_wdata = res_node_r;
    end else if (cmd.rem_unlink) begin
      lk_we    = !pos_one;
      lk_waddr = idx(prev_r);
      lk_wdata = lk_rdata;
    end else if (cmd.rem_free) begin
      lk_we    = 1'b1;
      lk_waddr = idx(cur_r);
      lk_wdata = free_head_r;
    end

    if (cmd.step) begin
      lk_raddr = idx(lk_rdata);
    end else if (cmd.ins_head || cmd.ins_tmp) begin
      lk_raddr = idx(free_head_r);
    end else begin
      lk_raddr = idx(cur_r);
    end
  end

  // payload table ports
  always_comb begin
    py_we    = 1'b0;
    py_waddr = idx(cur_r);
    py_wdata = '0;
    if (cmd.load_wr) begin
      py_we    = node_ok(num_r);
      py_waddr = idx(num_r);
      py_wdata = pay_r;
    end else if (cmd.ins_wr) begin
      py_we    = 1'b1;
      py_waddr = idx(free_head_r);
      py_wdata = pay_r;
    end else if (cmd.rem_unlink) begin
      py_we    = 1'b1;
      py_waddr = idx(cur_r);
      py_wdata = '0;
    end
  end

  allfl_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  allfl_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(NODE_COUNT)) u_pay_ram (
    .clk   (clk),
    .we    (py_we),
    .waddr (py_waddr),
    .wdata (py_wdata),
    .raddr (idx(cur_r)),
    .rdata (py_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_head_r <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == allfl_pkg::CFG_LIST_START) begin
        list_head_r <= cfg_data;
      end else if (cmd.ins_link && pos_one) begin
        list_head_r <= res_node_r;
      end else if (cmd.rem_unlink && pos_one) begin
        list_head_r <= lk_rdata;
      end

      if (cfg_we && cfg_index == allfl_pkg::CFG_FREE_START) begin
        free_head_r <= cfg_data;
      end else if (cmd.ins_wr) begin
        free_head_r <= lk_rdata;
      end else if (cmd.rem_free) begin
        free_head_r <= cur_r;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (cmd.capture) begin
      op_r         <= in_op;
      num_r        <= in_num;
      pos_r        <= in_pos;
      pay_r        <= in_pay;
      lnk_r        <= in_lnk;
      res_status_r <= allfl_pkg::ST_OK;
      res_node_r   <= '0;
      res_pay_r    <= '0;
    end
    if (cmd.fail_free) begin
      res_status_r <= allfl_pkg::ST_NO_FREE;
    end
    if (cmd.fail_pos) begin
      res_status_r <= allfl_pkg::ST_BAD_POS;
    end
    if (cmd.walk_init) begin
      cur_r <= list_head_r;
      rem_r <= rem_init;
    end
    if (cmd.step) begin
      prev_r <= cur_r;
      cur_r  <= lk_rdata;
      rem_r  <= rem_r - LINK_W'(1);
    end
    if (cmd.ins_head) begin
      tmp_r <= list_head_r;
    end
    if (cmd.ins_tmp) begin
      tmp_r <= lk_rdata;
    end
    if (cmd.ins_wr) begin
      res_node_r <= free_head_r;
    end
    if (cmd.rem_unlink) begin
      res_pay_r <= py_rdata;
    end
    if (cmd.rem_free) begin
      res_node_r <= cur_r;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_node_r   <= res_node_r;
      out_pay_r    <= res_pay_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_node   = out_node_r;
  assign out_pay    = out_pay_r;

  a_step_has_links: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> rem_r != '0)
    else $error("walk step with no links left to follow");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && out_status_r == $past(res_status_r))
    else $error("result not presented after emit");

endmodule

`default_nettype wire

### hw/rtl/allfl_ctrl.sv
// Controller state machine: sequences decode, list walk, table updates and result.
// Depends on allfl_pkg.
`default_nettype none

module allfl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire allfl_pkg::stat_t stat,
  output allfl_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WSTART,
    S_WSTEP,
    S_INS_PREV,
    S_INS_WR,
    S_INS_LINK,
    S_REM_UNLINK,
    S_REM_FREE,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          allfl_pkg::OP_LOAD: begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_RESP;
          end
          allfl_pkg::OP_INSERT: begin
            priority if (!stat.free_ok) begin
              cmd.fail_free = 1'b1;
              state_nxt     = S_RESP;
            end else if (stat.pos_one) begin
              cmd.ins_head = 1'b1;
              state_nxt    = S_INS_WR;
            end else if (stat.k_bad) begin
              cmd.fail_pos = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WSTART;
            end
          end
          allfl_pkg::OP_REMOVE: begin
            if (stat.k_bad) begin
              cmd.fail_pos = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WSTART;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_WSTART: begin
        if (!stat.cur_ok) begin
          cmd.fail_pos = 1'b1;
          state_nxt    = S_RESP;
        end else if (!stat.rem_zero) begin
          state_nxt = S_WSTEP;
        end else if (stat.op == allfl_pkg::OP_INSERT) begin
          state_nxt = S_INS_PREV;
        end else begin
          state_nxt = S_REM_UNLINK;
        end
      end
      S_WSTEP: begin
        cmd.step = 1'b1;
        if (stat.rem_one || !stat.rd_ok) begin
          state_nxt = S_WSTART;
        end
      end
      S_INS_PREV: begin
        cmd.ins_tmp = 1'b1;
        state_nxt   = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_nxt    = S_RESP;
      end
      S_REM_UNLINK: begin
        cmd.rem_unlink = 1'b1;
        state_nxt      = S_REM_FREE;
      end
      S_REM_FREE: begin
        cmd.rem_free = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in work");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_wr, cmd.ins_wr, cmd.ins_link, cmd.rem_unlink, cmd.rem_free}))
    else $error("conflicting table writes");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !stat.out_busy)
    else $error("result written over an untaken one");

endmodule

`default_nettype wire

### hw/rtl/array_linked_list_free_list_core.sv
// Array linked list with free list: load, insert at position, remove at position.
// Load, the unused op and errors caught at decode go straight to the result. Insert past
// position 2 and remove past the head walk the list first, L (1 to NODE_COUNT-1) being the
// links followed, one per cycle.
// One item at a time: the next is accepted only in idle, entered as its result is registered.
// Reset clears the list and free heads and the output valid; node tables are not cleared.
`default_nettype none

module array_linked_list_free_list_core #(
  parameter int NODE_COUNT   = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // tdata: node_number, position, payload, next_link (lowest bit up), zero padded
  input  wire logic [((3*$clog2(NODE_COUNT+1)+PAYLOAD_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: operation
  input  wire logic [allfl_pkg::OP_W-1:0]                in_tuser,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // tdata: node_taken, removed_payload (lowest bit up), zero padded
  output logic [(($clog2(NODE_COUNT+1)+PAYLOAD_BITS+7)/8)*8-1:0] out_tdata,
  // tuser: status
  output logic [allfl_pkg::STATUS_W-1:0]                 out_tuser,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [allfl_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0]           cfg_data
);

  localparam int LINK_W   = $clog2(NODE_COUNT+1);
  localparam int OUT_BITS = LINK_W + PAYLOAD_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  allfl_pkg::cmd_t  cmd;
  allfl_pkg::stat_t stat;

  logic [allfl_pkg::STATUS_W-1:0] res_status;
  logic [LINK_W-1:0]              res_node;
  logic [PAYLOAD_BITS-1:0]        res_pay;

  assign cfg_ready = 1'b1;

  allfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  allfl_dpath #(
    .NODE_COUNT   (NODE_COUNT),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_num     (in_tdata[LINK_W-1:0]),
    .in_pos     (in_tdata[2*LINK_W-1:LINK_W]),
    .in_pay     (in_tdata[2*LINK_W+PAYLOAD_BITS-1:2*LINK_W]),
    .in_lnk     (in_tdata[3*LINK_W+PAYLOAD_BITS-1:2*LINK_W+PAYLOAD_BITS]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_node   (res_node),
    .out_pay    (res_pay)
  );

  assign out_tuser = res_status;
  assign out_tdata = OUT_W'({res_pay, res_node});

endmodule

`default_nettype wire

### bench/array_linked_list_free_list_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for array_linked_list_free_list_core: load, insert and remove on the node
// table, checked against an in-bench list predictor. Depends on allfl_pkg and the core only.

module array_linked_list_free_list_core_tb;

  localparam int NODES       = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef logic [allfl_pkg::OP_W-1:0] op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  num;
    logic [4:0]  pos;
    logic [31:0] pay;
    logic [4:0]  lnk;
  } list_item_t;

  typedef struct packed {
    logic [allfl_pkg::STATUS_W-1:0] status;
    logic [4:0]                     node;
    logic [31:0]                    pay;
  } reply_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic [47:0]                       in_tdata = '0;
  op_t                               in_tuser = allfl_pkg::OP_NONE;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [39:0]                       out_tdata;
  logic [allfl_pkg::STATUS_W-1:0]    out_tuser;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [allfl_pkg::CFG_INDEX_W-1:0] cfg_index = allfl_pkg::CFG_LIST_START;
  logic [4:0]                        cfg_data = '0;

  array_linked_list_free_list_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted table and heads
  logic [31:0] tbl_pay [1:NODES];
  logic [4:0]  tbl_link[1:NODES];
  logic [4:0]  lst_head = '0;
  logic [4:0]  fre_head = '0;

  list_item_t op_queue[$];
  reply_t     replies[$];

  bit     in_fire, out_fire, cfg_fire;
  reply_t seen;
  int     quiet = 0;
  int     errors = 0;
  int     n_results = 0;
  int     n_by_op[4] = '{0, 0, 0, 0};
  int     n_by_status[4] = '{0, 0, 0, 0};
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     plan_len = 0;
  int     plan_free = 0;

  function automatic bit node_valid(logic [4:0] n);
    return n >= 1 && n <= NODES;
  endfunction

  function automatic logic [4:0] walk_to(int k);
    logic [4:0] cur;
    cur = lst_head;
    if (k < 1 || k > NODES) return 5'd0;
    for (int i = 1; i < k; i++) begin
      if (!node_valid(cur)) return 5'd0;
      cur = tbl_link[cur];
    end
    return node_valid(cur) ? cur : 5'd0;
  endfunction

  function automatic reply_t list_step(op_t op, logic [4:0] num, logic [4:0] pos,
                                       logic [31:0] pay, logic [4:0] lnk);
    reply_t     r;
    logic [4:0] prev;
    logic [4:0] f;
    logic [4:0] hit;
    r = '0;
    r.status = allfl_pkg::ST_OK;
    case (op)
      allfl_pkg::OP_LOAD: begin
        if (node_valid(num)) begin
          tbl_pay[num]  = pay;
          tbl_link[num] = lnk;
        end
      end
      allfl_pkg::OP_INSERT: begin
        prev = (pos >= 2) ? walk_to(int'(pos) - 1) : 5'd0;
        if (!node_valid(fre_head)) begin
          r.status = allfl_pkg::ST_NO_FREE;
        end else if (pos == 0 || (pos >= 2 && prev == 0)) begin
          r.status = allfl_pkg::ST_BAD_POS;
        end else begin
          f = fre_head;
          fre_head = tbl_link[f];
          tbl_pay[f] = pay;
          if (pos == 1) begin
            tbl_link[f] = lst_head;
            lst_head = f;
          end else begin
            tbl_link[f] = tbl_link[prev];
            tbl_link[prev] = f;
          end
          r.node = f;
        end
      end
      allfl_pkg::OP_REMOVE: begin
        hit = walk_to(int'(pos));
        if (hit == 0) begin
          r.status = allfl_pkg::ST_BAD_POS;
        end else begin
          if (pos == 1) begin
            lst_head = tbl_link[hit];
          end else begin
            prev = walk_to(int'(pos) - 1);
            tbl_link[prev] = tbl_link[hit];
          end
          r.pay = tbl_pay[hit];
          tbl_pay[hit] = '0;
          tbl_link[hit] = fre_head;
          fre_head = hit;
          r.node = hit;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_reply(reply_t got);
    reply_t want;
    n_results++;
    n_by_status[got.status]++;
    if (replies.size() == 0) begin
      report_mismatch("result with nothing pending, node", got.node, 0);
    end else begin
      want = replies.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.node != want.node) report_mismatch("node_taken", got.node, want.node);
      if (got.pay != want.pay) report_mismatch("removed_payload", got.pay, want.pay);
    end
  endtask

  // sample at rising edge: config, results, accepted items, watchdog
  always @(posedge clk) begin
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (cfg_fire) begin
      case (cfg_index)
        allfl_pkg::CFG_LIST_START: lst_head = cfg_data;
        allfl_pkg::CFG_FREE_START: fre_head = cfg_data;
        default: ;
      endcase
    end
    if (out_fire) begin
      seen.status = out_tuser;
      seen.node   = out_tdata[4:0];
      seen.pay    = out_tdata[36:5];
      check_reply(seen);
    end
    if (in_fire) begin
      n_by_op[in_tuser]++;
      replies.push_back(list_step(in_tuser, in_tdata[4:0], in_tdata[9:5], in_tdata[41:10],
                                  in_tdata[46:42]));
    end
    if (!rst_n || in_fire || out_fire || cfg_fire) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results pending", quiet,
                 replies.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_fire) op_queue.delete(0);
      if (op_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= op_queue[0].op;
        in_tdata  <= {1'b0, op_queue[0].lnk, op_queue[0].pay, op_queue[0].pos, op_queue[0].num};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with optional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(logic [allfl_pkg::CFG_INDEX_W-1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (op_queue.size() != 0 || in_tvalid || replies.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // plan_len/plan_free track list and free sizes for well-formed sequences
  task automatic queue_item(op_t op, logic [4:0] num, logic [4:0] pos,
                            logic [31:0] pay, logic [4:0] lnk);
    list_item_t it;
    it = '{op: op, num: num, pos: pos, pay: pay, lnk: lnk};
    op_queue.push_back(it);
    if (op == allfl_pkg::OP_INSERT && plan_free > 0 && pos >= 1 && pos <= plan_len + 1) begin
      plan_len++;
      plan_free--;
    end else if (op == allfl_pkg::OP_REMOVE && pos >= 1 && pos <= plan_len) begin
      plan_len--;
      plan_free++;
    end
  endtask

  function automatic logic [31:0] rand_payload();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // fresh free chain over all nodes, empty list
  task automatic rebuild(bit descending);
    wait_idle();
    write_reg(allfl_pkg::CFG_LIST_START, 5'd0);
    write_reg(allfl_pkg::CFG_FREE_START, descending ? 5'd16 : 5'd1);
    for (int n = 1; n <= NODES; n++) begin
      queue_item(allfl_pkg::OP_LOAD, 5'(n), 5'($urandom), rand_payload(),
                 descending ? 5'(n - 1) : (n == NODES ? 5'd0 : 5'(n + 1)));
    end
    plan_len  = 0;
    plan_free = NODES;
  endtask

  task automatic plan_random_op();
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      queue_item(allfl_pkg::OP_NONE, 5'($urandom), 5'($urandom), $urandom, 5'($urandom));
    end else if (r < 7) begin
      queue_item(allfl_pkg::OP_LOAD,
                 $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31)), 5'($urandom),
                 $urandom, 5'($urandom));
    end else if (r < 15) begin
      queue_item($urandom_range(1) ? allfl_pkg::OP_INSERT : allfl_pkg::OP_REMOVE,
                 5'($urandom), 5'($urandom_range(31)), rand_payload(), 5'($urandom));
    end else if (plan_len == 0 || (plan_free != 0 && $urandom_range(1))) begin
      queue_item(allfl_pkg::OP_INSERT, 5'($urandom), 5'($urandom_range(1, plan_len + 1)),
                 rand_payload(), 5'($urandom));
    end else begin
      queue_item(allfl_pkg::OP_REMOVE, 5'($urandom), 5'($urandom_range(1, plan_len)),
                 rand_payload(), 5'($urandom));
    end
  endtask

  // arbitrary heads and links: cycles, out-of-range links and heads
  task automatic scramble_phase();
    wait_idle();
    write_reg(allfl_pkg::CFG_LIST_START, 5'($urandom_range(31)));
    write_reg(allfl_pkg::CFG_FREE_START, 5'($urandom_range(31)));
    for (int i = 0; i < 30; i++) begin
      queue_item(allfl_pkg::OP_LOAD,
                 $urandom_range(3) != 0 ? 5'($urandom_range(1, NODES)) : 5'($urandom),
                 5'($urandom), rand_payload(),
                 $urandom_range(3) != 0 ? 5'($urandom_range(0, NODES)) : 5'($urandom));
    end
    for (int i = 0; i < 70; i++) begin
      queue_item(op_t'($urandom_range(3)), 5'($urandom),
                 $urandom_range(3) != 0 ? 5'($urandom_range(1, NODES + 1)) : 5'($urandom),
                 rand_payload(), 5'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 20;
    rx_idle_pct = 50;

    // directed: small free chain 1..4, empty list
    write_reg(allfl_pkg::CFG_LIST_START, 5'd0);
    write_reg(allfl_pkg::CFG_FREE_START, 5'd1);
    queue_item(allfl_pkg::OP_LOAD, 5'd1, 5'd0, 32'h0, 5'd2);
    queue_item(allfl_pkg::OP_LOAD, 5'd2, 5'd0, 32'hFFFF_FFFF, 5'd3);
    queue_item(allfl_pkg::OP_LOAD, 5'd3, 5'd0, 32'hA5A5_5A5A, 5'd4);
    queue_item(allfl_pkg::OP_LOAD, 5'd4, 5'd0, 32'h5A5A_A5A5, 5'd0);
    queue_item(allfl_pkg::OP_LOAD, 5'd5, 5'd0, 32'h1234_5678, 5'd31);
    queue_item(allfl_pkg::OP_LOAD, 5'd16, 5'd0, 32'hFFFF_FFFF, 5'd0);
    queue_item(allfl_pkg::OP_LOAD, 5'd0, 5'd0, 32'hDEAD_BEEF, 5'd1);
    queue_item(allfl_pkg::OP_LOAD, 5'd31, 5'd31, 32'hFFFF_FFFF, 5'd31);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd1, 32'h1111_1111, 5'd0);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd2, 32'h2222_2222, 5'd0);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd2, 32'h3333_3333, 5'd0);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd5, 32'h4444_4444, 5'd0);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd0, 32'h5555_5555, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd0, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd4, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd17, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd31, 5'd31, 32'hFFFF_FFFF, 5'd31);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd2, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd2, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd1, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd1, 32'h0, 5'd0);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd2, 32'h6666_6666, 5'd0);
    queue_item(allfl_pkg::OP_NONE, 5'd31, 5'd31, 32'hFFFF_FFFF, 5'd31);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd1, 32'hFFFF_FFFF, 5'd0);

    // empty and out-of-range free heads, list head at the top node
    wait_idle();
    write_reg(allfl_pkg::CFG_FREE_START, 5'd0);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd1, 32'h7777_7777, 5'd0);
    wait_idle();
    write_reg(allfl_pkg::CFG_FREE_START, 5'd20);
    queue_item(allfl_pkg::OP_INSERT, 5'd0, 5'd0, 32'h8888_8888, 5'd0);
    wait_idle();
    write_reg(allfl_pkg::CFG_LIST_START, 5'd16);
    queue_item(allfl_pkg::OP_REMOVE, 5'd0, 5'd1, 32'h0, 5'd0);

    // phase 1: receiver holds off long enough to back up the input
    rebuild(1'b0);
    hold_requests++;
    for (int i = 0; i < 220; i++) plan_random_op();

    // phase 2: roles swapped, sender pauses for a full drain midway
    rebuild(1'b1);
    tx_idle_pct = 50;
    rx_idle_pct = 20;
    for (int i = 0; i < 110; i++) plan_random_op();
    wait_idle();
    for (int i = 0; i < 110; i++) plan_random_op();

    // phase 3: no idling
    rebuild(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 220; i++) plan_random_op();
    scramble_phase();

    wait_idle();
    repeat (40) @(negedge clk);
    $display("Ran %0d items: %0d loads, %0d inserts, %0d removes, %0d unused ops",
             n_by_op[0] + n_by_op[1] + n_by_op[2] + n_by_op[3],
             n_by_op[allfl_pkg::OP_LOAD], n_by_op[allfl_pkg::OP_INSERT],
             n_by_op[allfl_pkg::OP_REMOVE], n_by_op[allfl_pkg::OP_NONE]);
    $display("Checked %0d results: %0d ok, %0d free list empty, %0d bad position; %0d errors",
             n_results, n_by_status[allfl_pkg::ST_OK], n_by_status[allfl_pkg::ST_NO_FREE],
             n_by_status[allfl_pkg::ST_BAD_POS], errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
